// ===== src/sorted_min_priority_queue_assert.svh =====
// Assertion macros for the sorted minimum priority queue.
// Used at the end of the top level; expects i_clk and i_rst_n in scope.
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define SMPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smpq check failed");

// Next-cycle implication, checked out of reset
`define SMPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smpq check failed");

`else

`define SMPQ_ASSERT_NOW(lbl, ante, cons)
`define SMPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/smpq_pkg.sv =====
// Shared types and constants for the sorted minimum priority queue.
// No dependencies; imported by the controller, the datapath and the top level.
package smpq_pkg;

    localparam int CAPACITY_DEF = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] task_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic signed [31:0] head_value;
        logic [4:0]         entry_count;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the accepted item
        logic rd_prev;    // read entry idx-1
        logic rd_idx;     // read entry idx
        logic rd_head;    // read entry 0
        logic wr_up;      // write read data at idx, idx--
        logic wr_val;     // write new value at idx
        logic wr_down;    // write read data at idx-1, idx++
        logic take_rm;    // latch removed value, idx++
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;   // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic idx_at_cnt;
        logic greater;    // read data > value being inserted
        logic out_free;
    } t_sts;

endpackage

// ===== src/smpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/smpq_ctrl.sv =====
// Controller for the sorted minimum priority queue: sequences insert scans,
// remove shifts, the head read and the result transfer. Uses smpq_pkg.
module smpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_kind,
    input  smpq_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output smpq_pkg::t_cmd o_cmd
);
    import smpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_REM_TAKE,
        S_REM_CHK,
        S_REM_MOVE,
        S_HEAD,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_kind == OP_INSERT) begin
                        n_state = i_sts.full ? S_HEAD : S_INS_CHK;
                    end else if (i_sts.empty) begin
                        n_state = S_HEAD;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_REM_TAKE;
                    end
                end
            end
            S_INS_CHK: begin
                if (i_sts.idx_zero) begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_HEAD;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.greater) begin
                    o_cmd.wr_up = 1'b1;
                    n_state     = S_INS_CHK;
                end else begin
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_HEAD;
                end
            end
            S_REM_TAKE: begin
                o_cmd.take_rm = 1'b1;
                n_state       = S_REM_CHK;
            end
            S_REM_CHK: begin
                if (i_sts.idx_at_cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_HEAD;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_REM_MOVE;
                end
            end
            S_REM_MOVE: begin
                o_cmd.wr_down = 1'b1;
                n_state       = S_REM_CHK;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== src/smpq_dp.sv =====
// Datapath for the sorted minimum priority queue: entry store, count, scan
// index, item registers and the result register. Uses smpq_pkg, smpq_ram.
module smpq_dp #(
    parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smpq_pkg::t_in_item  i_in_data,
    input  smpq_pkg::t_cmd      i_cmd,
    input  logic                i_out_ready,
    output smpq_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output smpq_pkg::t_out_item o_out_data
);
    import smpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic signed [31:0] r_value;
    logic signed [31:0] r_removed;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CW-1:0]      w_idx_m1;
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [31:0]        w_wdata, w_rdata;
    logic [CW+4:0]      w_cnt_ext;

    assign w_idx_m1 = r_idx - CW'(1);

    // store port muxing
    always_comb begin
        w_we    = i_cmd.wr_up || i_cmd.wr_val || i_cmd.wr_down;
        w_waddr = i_cmd.wr_down ? w_idx_m1[AW-1:0] : r_idx[AW-1:0];
        w_wdata = i_cmd.wr_val ? r_value : w_rdata;
        w_re    = i_cmd.rd_prev || i_cmd.rd_idx || i_cmd.rd_head;
        if (i_cmd.rd_prev) begin
            w_raddr = w_idx_m1[AW-1:0];
        end else if (i_cmd.rd_idx) begin
            w_raddr = r_idx[AW-1:0];
        end else begin
            w_raddr = '0;
        end
    end

    smpq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // status back to the controller
    always_comb begin
        o_sts.full       = (r_count == CW'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.idx_at_cnt = (r_idx == r_count);
        o_sts.greater    = ($signed(w_rdata) > r_value);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // item registers and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= i_in_data.task_value;
            r_removed <= '0;
            r_idx     <= (i_in_data.kind == OP_REMOVE) ? '0 : r_count;
            if (i_in_data.kind == OP_INSERT && o_sts.full) begin
                r_status <= ST_FULL;
            end else if (i_in_data.kind == OP_REMOVE && o_sts.empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_DONE;
            end
        end
        if (i_cmd.take_rm) begin
            r_removed <= w_rdata;
        end
        if (i_cmd.wr_up) begin
            r_idx <= w_idx_m1;
        end else if (i_cmd.wr_down || i_cmd.take_rm) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign w_cnt_ext = {5'd0, r_count};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status        <= r_status;
            r_out.removed_value <= r_removed;
            r_out.head_value    <= o_sts.empty ? '0 : $signed(w_rdata);
            r_out.entry_count   <= w_cnt_ext[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== src/sorted_min_priority_queue.sv =====
// Sorted minimum priority queue: up to CAPACITY signed 32-bit values kept in
// ascending order in one RAM; inserts go after equal values, removes take the
// head. Works on one item at a time. In an insert each stored entry greater
// than the new value needs a RAM read, then a write, and one more read and
// compare stops the scan; when the new value becomes the head the scan stops
// at entry 0 with no final compare. In a remove every entry behind the head
// is read and written back one place forward. A rejected item (insert while
// full, remove while empty) skips the scan and goes straight to the head read.
// The single read port with registered data sets these steps. The result
// waits in an output register, so the next item is taken while it is still
// pending. No clearing pass after reset; the store is read past the entry
// count only for the head read of an empty queue, whose value shows as zero.
// entry_count shows the count masked to 5 bits.
module sorted_min_priority_queue #(
    parameter int CAPACITY = smpq_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smpq_pkg::t_out_item o_out_data
);
    import smpq_pkg::*;

    `include "sorted_min_priority_queue_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_reject;

    smpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    smpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // pending result that carries a reject status
    assign w_reject = o_out_valid && (o_out_data.status != ST_DONE);

    // a rejected item never reports a removed value
    `SMPQ_ASSERT_NOW(a_reject_no_removed, w_reject, o_out_data.removed_value == 0)
    // the count can not be both at capacity and zero
    `SMPQ_ASSERT_NOW(a_full_not_empty, w_sts.full, !w_sts.empty)
    // one item at a time: ready drops after a transfer in
    `SMPQ_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)
    // the result register is only loaded when free
    `SMPQ_ASSERT_NOW(a_no_overwrite, w_cmd.out_load, w_sts.out_free)
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for sorted_min_priority_queue (default capacity).
// Depends on smpq_pkg for the item types, operation codes and status codes.
// A directed table and random insert/remove traffic are checked against a shadow queue.
module testbench;
    import smpq_pkg::*;

    localparam int QCAP           = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 1330;
    localparam int HOLD_AT        = 300;
    localparam int DRAIN_AT       = 800;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 64;
    localparam int REPORT_LIMIT   = 10;

    // One row of directed stimulus; the result is typed in only when typed is set
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } dir_row_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    // Shadow copy of the sorted store
    logic signed [31:0] shadow_vals [QCAP];
    int                 shadow_count;

    t_out_item awaited_results [$];
    int        mismatches;
    int        results_seen;
    int        idle_cycles;
    int        burst_left;
    bit        hold_outputs;

    sorted_min_priority_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow queue and return the result it gives
    function automatic t_out_item next_queue_result(t_in_item it);
        t_out_item          r;
        logic signed [31:0] v;
        int                 pos;
        r = '0;
        r.status = ST_DONE;
        v = it.task_value;
        if (it.kind == OP_INSERT) begin
            if (shadow_count >= QCAP) begin
                r.status = ST_FULL;
            end else begin
                // new value goes after every equal value
                pos = 0;
                while (pos < shadow_count && shadow_vals[pos] <= v) pos++;
                for (int i = shadow_count; i > pos; i--) shadow_vals[i] = shadow_vals[i - 1];
                shadow_vals[pos] = v;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.removed_value = shadow_vals[0];
                for (int i = 0; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i + 1];
                shadow_count--;
            end
        end
        r.head_value  = (shadow_count > 0) ? shadow_vals[0] : 32'sd0;
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    function automatic dir_row_t plain_row(logic kind, logic signed [31:0] v);
        dir_row_t r;
        r.item.kind       = kind;
        r.item.task_value = v;
        r.typed           = 1'b0;
        r.result          = '0;
        return r;
    endfunction

    function automatic dir_row_t expect_row(logic kind, logic signed [31:0] v, t_status st,
                                            logic signed [31:0] rm, logic signed [31:0] hd,
                                            logic [4:0] cnt);
        dir_row_t r;
        r = plain_row(kind, v);
        r.typed                = 1'b1;
        r.result.status        = st;
        r.result.removed_value = rm;
        r.result.head_value    = hd;
        r.result.entry_count   = cnt;
        return r;
    endfunction

    // Value mix: full range, a narrow band for duplicates, extremes, small positives
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return 32'(int'($urandom_range(0, 16)) - 8);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default:    return $urandom_range(0, 1000);
        endcase
    endfunction

    // Sender bursts: at the start of a burst, maybe drop valid for a random gap
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Offer one item, hold it until the transfer, then record its expected result
    task automatic offer(input dir_row_t r);
        t_out_item res;
        i_in_valid <= 1'b1;
        i_in_data  <= r.item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = next_queue_result(r.item);
        if (r.typed) res = r.result;
        awaited_results.push_back(res);
    endtask

    // Lower valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Output checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("result %0d arrived with none outstanding", results_seen));
            end else begin
                want = awaited_results.pop_front();
                if (want.status !== o_out_data.status ||
                    want.removed_value !== o_out_data.removed_value ||
                    want.head_value !== o_out_data.head_value ||
                    want.entry_count !== o_out_data.entry_count) begin
                    note_failure($sformatf(
                        "result %0d: exp st=%0d rm=%0d hd=%0d n=%0d, got st=%0d rm=%0d hd=%0d n=%0d",
                        results_seen, want.status, want.removed_value, want.head_value,
                        want.entry_count, o_out_data.status, o_out_data.removed_value,
                        o_out_data.head_value, o_out_data.entry_count));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: rotating stall mask per segment, plus one long hold on request
    initial begin
        logic [15:0] stall_mask;
        int          phase;
        int          seg_left;
        stall_mask = 16'hFFFF;
        phase      = 0;
        seg_left   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(32, 128);
                    case ($urandom_range(0, 3))
                        0:       stall_mask = 16'hFFFF;
                        1:       stall_mask = 16'($urandom) | 16'h0001;
                        2:       stall_mask = 16'($urandom & $urandom) | 16'h0001;
                        default: stall_mask = 16'($urandom | $urandom);
                    endcase
                end
                seg_left--;
                i_out_ready <= stall_mask[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    // Stimulus and final verdict
    initial begin
        dir_row_t rows [$];
        dir_row_t r;
        int       ins_pct;
        int       mode_left;
        shadow_count = 0;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        hold_outputs = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty remove, extremes, duplicates, fill to capacity, full insert, then removes and one more insert
        rows.push_back(expect_row(OP_REMOVE, 32'sd0, ST_EMPTY, 32'sd0, 32'sd0, 5'd0));
        rows.push_back(expect_row(OP_INSERT, 32'sh7FFF_FFFF, ST_DONE, 32'sd0,
                                  32'sh7FFF_FFFF, 5'd1));
        rows.push_back(expect_row(OP_INSERT, 32'sh8000_0000, ST_DONE, 32'sd0,
                                  32'sh8000_0000, 5'd2));
        rows.push_back(plain_row(OP_INSERT, 32'sd0));
        rows.push_back(plain_row(OP_INSERT, 32'sd0));
        rows.push_back(plain_row(OP_INSERT, -32'sd1));
        rows.push_back(plain_row(OP_INSERT, 32'sd1));
        rows.push_back(plain_row(OP_INSERT, 32'sh5555_5555));
        rows.push_back(plain_row(OP_INSERT, 32'shAAAA_AAAA));
        rows.push_back(plain_row(OP_INSERT, 32'sh7FFF_FFFF));
        rows.push_back(plain_row(OP_INSERT, 32'sh8000_0000));
        rows.push_back(plain_row(OP_INSERT, 32'sd5));
        rows.push_back(plain_row(OP_INSERT, -32'sd5));
        rows.push_back(plain_row(OP_INSERT, 32'sh4000_0000));
        rows.push_back(plain_row(OP_INSERT, 32'shC000_0000));
        rows.push_back(plain_row(OP_INSERT, 32'sd2));
        rows.push_back(plain_row(OP_INSERT, 32'sd3));
        rows.push_back(expect_row(OP_INSERT, 32'sh1234_5678, ST_FULL, 32'sd0,
                                  32'sh8000_0000, 5'd16));
        rows.push_back(expect_row(OP_REMOVE, 32'sd0, ST_DONE, 32'sh8000_0000,
                                  32'sh8000_0000, 5'd15));
        rows.push_back(plain_row(OP_REMOVE, -32'sd1));
        rows.push_back(plain_row(OP_REMOVE, 32'sh7FFF_FFFF));
        rows.push_back(plain_row(OP_INSERT, 32'sh8000_0000));
        foreach (rows[i]) begin
            pace();
            offer(rows[i]);
        end

        // Random: fill, drain and mixed phases
        mode_left = 0;
        ins_pct   = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 15;
                    default: ins_pct = 50;
                endcase
            end
            mode_left--;
            if (n == HOLD_AT) hold_outputs = 1'b1;
            if (n == DRAIN_AT) drain();
            pace();
            r = plain_row(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE, pick_value());
            offer(r);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sorted_min_priority_queue.f =====
+incdir+src
src/smpq_pkg.sv
src/smpq_ram.sv
src/smpq_ctrl.sv
src/smpq_dp.sv
src/sorted_min_priority_queue.sv
tb/sv/testbench.sv
